@@ sv/via_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// via_pkg: shared types and constants
// Item structs, opcodes, register addresses and flag masks.
// ---------------------------------------------------------------------------
package via_pkg;

	typedef enum logic [2:0] {
		OP_WRITE = 3'd0,
		OP_READ  = 3'd1,
		OP_TICK  = 3'd2,
		OP_CA1   = 3'd3,
		OP_CA2   = 3'd4,
		OP_CB1   = 3'd5,
		OP_CB2   = 3'd6,
		OP_NONE  = 3'd7
	} opcode_t;

	localparam logic [3:0] RA_ORB  = 4'h0;
	localparam logic [3:0] RA_ORA  = 4'h1;
	localparam logic [3:0] RA_DDRB = 4'h2;
	localparam logic [3:0] RA_DDRA = 4'h3;
	localparam logic [3:0] RA_T1CL = 4'h4;
	localparam logic [3:0] RA_T1CH = 4'h5;
	localparam logic [3:0] RA_T1LL = 4'h6;
	localparam logic [3:0] RA_T1LH = 4'h7;
	localparam logic [3:0] RA_T2CL = 4'h8;
	localparam logic [3:0] RA_T2CH = 4'h9;
	localparam logic [3:0] RA_SR   = 4'hA;
	localparam logic [3:0] RA_ACR  = 4'hB;
	localparam logic [3:0] RA_PCR  = 4'hC;
	localparam logic [3:0] RA_IFR  = 4'hD;
	localparam logic [3:0] RA_IER  = 4'hE;
	localparam logic [3:0] RA_ORAN = 4'hF;

	localparam logic [7:0] FL_CA2 = 8'h01;
	localparam logic [7:0] FL_CA1 = 8'h02;
	localparam logic [7:0] FL_SR  = 8'h04;
	localparam logic [7:0] FL_CB2 = 8'h08;
	localparam logic [7:0] FL_CB1 = 8'h10;
	localparam logic [7:0] FL_T2  = 8'h20;
	localparam logic [7:0] FL_T1  = 8'h40;

	localparam logic [16:0] TIMER_RESET = 17'h1FFFE;

	typedef struct packed {
		logic [2:0] opcode;
		logic [3:0] reg_addr;
		logic [7:0] write_data;
		logic       line_level;
		logic [3:0] tick_cycles;
		logic [7:0] port_a_pins;
		logic [7:0] port_b_pins;
	} in_item_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic [7:0] port_a_drive;
		logic [7:0] port_b_drive;
		logic       ca2_drive;
		logic       ca2_pulse;
		logic       cb1_drive;
		logic       cb2_drive;
		logic       cb2_pulse;
		logic       irq_active;
		logic       force_irq;
		logic       timer1_expired;
	} out_item_t;

	// shift unit control/status
	typedef struct packed {
		logic       start;
		logic [7:0] data;
	} sh_load_t;

	typedef struct packed {
		logic [7:0] data;
		logic [4:0] count;
		logic [1:0] lines;
	} sh_state_t;

endpackage

@@ sv/via_shift.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// via_sr_unit: shift-out register
// Advances one system clock per step; loaded by a shift register write.
// ---------------------------------------------------------------------------
module via_sr_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  via_pkg::sh_load_t  load,
	input  logic               step,
	output via_pkg::sh_state_t st,
	output logic               empty
);
	logic [7:0] data_q;
	logic [4:0] count_q;
	logic [1:0] lines_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_q  <= '0;
			count_q <= '0;
			lines_q <= '0;
		end else if (load.start) begin
			data_q  <= load.data;
			count_q <= 5'd16;
		end else if (step && count_q != 5'd0) begin
			count_q    <= count_q - 5'd1;
			lines_q[0] <= ~count_q[0];
			if (!count_q[0]) begin
				lines_q[1] <= data_q[7];
				data_q     <= {data_q[6:0], 1'b0};
			end
		end
	end

	// empty after this step (for flag setting)
	assign empty = (count_q == 5'd0) || (count_q == 5'd1);
	assign st    = '{data: data_q, count: count_q, lines: lines_q};
endmodule

@@ sv/versatile_interface_adapter.sv @@
`timescale 1ns / 1ps
// Sequence: writes, reads and line items pass through EXEC, then DONE with the result.
// Tick items go EXEC, then RELD for r timer 1 reload steps (0 to 4, one add of
// latch + 4 per cycle) if timer 1 underflows, then in shift-out mode SHFT, which
// makes n shift steps (one per cycle, n = tick_cycles saturated at MAX_TICK_CYCLES).
// Throughput: one item at a time; in_ready returns the cycle after the result is taken.
// Reset: asynchronous, active low; registers to power-on values, timers 0x1FFFE.
// ---------------------------------------------------------------------------
// versatile_interface_adapter: 6522-style port, timer and shift block
// Sequencer that steps a single shift unit once per tick cycle in shift-out mode.
// ---------------------------------------------------------------------------
module versatile_interface_adapter #(
	parameter int MAX_TICK_CYCLES = 15
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  via_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output via_pkg::out_item_t out_data
);
	localparam int CW = $clog2(MAX_TICK_CYCLES + 1);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_EXEC = 5'b00010,
		ST_RELD = 5'b00100,
		ST_SHFT = 5'b01000,
		ST_DONE = 5'b10000
	} state_t;

	state_t state_q;
	state_t tick_next;
	via_pkg::in_item_t item_q;
	logic [CW-1:0] cyc_q;

	logic [7:0] ora_q, orb_q, ddra_q, ddrb_q, ila_q, ilb_q, acr_q, pcr_q, ifr_q;
	logic [6:0] ier_q;
	logic [16:0] t1l_q, t2l_q;
	logic [18:0] t1c_q;
	logic [31:0] t2c_q;
	logic t1d_q, t2d_q, pb7_q;
	logic [3:0] lv_q;
	logic [7:0] rd_q;
	logic ca2p_q, cb2p_q, force_q, t1x_q;

	via_pkg::sh_load_t  sh_load;
	via_pkg::sh_state_t sh_st;
	logic sh_step, sh_empty, shifting;

	assign shifting = (acr_q[4:2] == 3'b110);

	via_sr_unit u_shift (
		.clk(clk), .arst_n(arst_n), .load(sh_load), .step(sh_step),
		.st(sh_st), .empty(sh_empty)
	);

	// tick count, saturated
	logic [CW-1:0] cyc_sat;
	always_comb begin
		if (32'(in_data.tick_cycles) > 32'(MAX_TICK_CYCLES))
			cyc_sat = CW'(MAX_TICK_CYCLES);
		else
			cyc_sat = CW'(in_data.tick_cycles);
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_DONE);
	assign sh_step   = (state_q == ST_SHFT) && (cyc_q != '0);
	assign sh_load.start = (state_q == ST_EXEC) && (item_q.opcode == via_pkg::OP_WRITE)
		&& (item_q.reg_addr == via_pkg::RA_SR);
	assign sh_load.data  = item_q.write_data;

	function automatic logic [7:0] pb7m(input logic [7:0] v, input logic [7:0] acr,
		input logic pb7);
		pb7m = acr[7] ? {pb7, v[6:0]} : v;
	endfunction

	// ---- timer 1 tick arithmetic (signed, count >= -3 on entry) ----
	// One subtract in EXEC; if below the floor, RELD adds latch + 4 once per
	// cycle until the count is back at -3 or above (at most four adds).
	logic [CW-1:0] cyc_t;
	logic signed [19:0] t1_sub, t1_rel;
	logic t1_under;
	logic [31:0] t2_sub;
	always_comb begin
		cyc_t    = item_q.tick_cycles > 4'(MAX_TICK_CYCLES > 15 ? 15 : MAX_TICK_CYCLES)
			? CW'(MAX_TICK_CYCLES) : CW'(item_q.tick_cycles);
		t1_sub   = $signed({t1c_q[18], t1c_q}) - $signed({1'b0, 19'(cyc_t)});
		t1_under = t1_sub < -20'sd3;
		t1_rel   = $signed({t1c_q[18], t1c_q}) + $signed({3'b000, t1l_q}) + 20'sd4;
		t2_sub   = t2c_q - 32'(cyc_t);
		if (t1_under)
			tick_next = ST_RELD;
		else if (shifting)
			tick_next = ST_SHFT;
		else
			tick_next = ST_DONE;
	end

	// IRQ summary bit, derived from low flags
	logic [7:0] ifr_n;
	assign ifr_n = {|(ifr_q[6:0] & ier_q), ifr_q[6:0]};

	// ---- main register state ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cyc_q <= '0;
			ora_q <= '0; orb_q <= '0; ddra_q <= '0; ddrb_q <= '0;
			ila_q <= '0; ilb_q <= '0; acr_q <= '0; pcr_q <= '0; ifr_q <= '0;
			ier_q <= '0;
			t1l_q <= via_pkg::TIMER_RESET; t2l_q <= via_pkg::TIMER_RESET;
			t1c_q <= 19'(via_pkg::TIMER_RESET); t2c_q <= 32'(via_pkg::TIMER_RESET);
			t1d_q <= 1'b1; t2d_q <= 1'b1; pb7_q <= 1'b1;
			lv_q <= '0;
			rd_q <= '0; ca2p_q <= 1'b0; cb2p_q <= 1'b0; force_q <= 1'b0; t1x_q <= 1'b0;
			item_q <= '0;
		end else begin
			case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					item_q <= in_data;
					cyc_q  <= cyc_sat;
					state_q <= ST_EXEC;
					rd_q <= '0; ca2p_q <= 1'b0; cb2p_q <= 1'b0;
					force_q <= 1'b0; t1x_q <= 1'b0;
				end
			end
			ST_EXEC: begin
				state_q <= (item_q.opcode == via_pkg::OP_TICK) ? tick_next : ST_DONE;
				case (item_q.opcode)
				via_pkg::OP_WRITE: begin
					case (item_q.reg_addr)
					via_pkg::RA_ORA: begin
						ifr_q[1] <= 1'b0;
						if (!(pcr_q[3:1] == 3'b001 || pcr_q[3:1] == 3'b011)) ifr_q[0] <= 1'b0;
						if (pcr_q[3:1] == 3'b100) lv_q[1] <= 1'b0;
						if (pcr_q[3:1] == 3'b101) begin ca2p_q <= 1'b1; lv_q[1] <= 1'b1; end
						ora_q <= item_q.write_data;
					end
					via_pkg::RA_ORAN: ora_q <= item_q.write_data;
					via_pkg::RA_ORB: begin
						ifr_q[4] <= 1'b0;
						if (!(pcr_q[7:5] == 3'b001 || pcr_q[7:5] == 3'b011)) ifr_q[3] <= 1'b0;
						orb_q <= item_q.write_data;
						if (pcr_q[7:5] == 3'b100) lv_q[3] <= 1'b0;
						if (pcr_q[7:5] == 3'b101) begin cb2p_q <= 1'b1; lv_q[3] <= 1'b1; end
					end
					via_pkg::RA_DDRA: ddra_q <= item_q.write_data;
					via_pkg::RA_DDRB: ddrb_q <= item_q.write_data;
					via_pkg::RA_ACR: begin
						acr_q <= item_q.write_data;
						if (!item_q.write_data[7]) pb7_q <= 1'b1;
					end
					via_pkg::RA_PCR: begin
						pcr_q <= item_q.write_data;
						if (item_q.write_data[3:1] == 3'b110) lv_q[1] <= 1'b0;
						else if (item_q.write_data[3]) lv_q[1] <= 1'b1;
						if (item_q.write_data[7:5] == 3'b110) lv_q[3] <= 1'b0;
						else if (item_q.write_data[7]) lv_q[3] <= 1'b1;
					end
					via_pkg::RA_SR: ifr_q[2] <= 1'b0;
					via_pkg::RA_T1CL, via_pkg::RA_T1LL:
						t1l_q[8:1] <= item_q.write_data;
					via_pkg::RA_T1LH: begin
						t1l_q[16:9] <= item_q.write_data;
						ifr_q[6] <= 1'b0;
					end
					via_pkg::RA_T1CH: begin
						if (acr_q[7:6] == 2'b10) pb7_q <= 1'b0;
						t1l_q[16:9] <= item_q.write_data;
						t1c_q <= 19'({item_q.write_data, t1l_q[8:0]}) + 19'd1;
						t1d_q <= 1'b0;
						ifr_q[6] <= 1'b0;
					end
					via_pkg::RA_T2CL: t2l_q[8:1] <= item_q.write_data;
					via_pkg::RA_T2CH: begin
						if ((t2c_q == 32'hFFFFFFFD && ier_q[5]) || (ifr_q[5] && ier_q[5]))
							force_q <= 1'b1;
						t2l_q[16:9] <= item_q.write_data;
						t2c_q <= 32'({item_q.write_data, t2l_q[8:0]}) + (acr_q[5] ? 32'd0 : 32'd1);
						ifr_q[5] <= 1'b0;
						t2d_q <= 1'b0;
					end
					via_pkg::RA_IER: begin
						if (item_q.write_data[7]) ier_q <= ier_q | item_q.write_data[6:0];
						else ier_q <= ier_q & ~item_q.write_data[6:0];
					end
					default: ifr_q[6:0] <= ifr_q[6:0] & ~item_q.write_data[6:0];
					endcase
				end
				via_pkg::OP_READ: begin
					case (item_q.reg_addr)
					via_pkg::RA_ORA, via_pkg::RA_ORAN: begin
						if (item_q.reg_addr == via_pkg::RA_ORA) begin
							ifr_q[1] <= 1'b0;
							if (!(pcr_q[3:1] == 3'b001 || pcr_q[3:1] == 3'b011)) ifr_q[0] <= 1'b0;
						end
						rd_q <= (ora_q & ddra_q)
							| ((acr_q[0] ? ila_q : item_q.port_a_pins) & ~ddra_q);
					end
					via_pkg::RA_ORB: begin
						ifr_q[4] <= 1'b0;
						if (!(pcr_q[7:5] == 3'b001 || pcr_q[7:5] == 3'b011)) ifr_q[3] <= 1'b0;
						if (acr_q[1]) rd_q <= (orb_q & ddrb_q) | (ilb_q & ~ddrb_q);
						else rd_q <= pb7m((orb_q & ddrb_q) | (item_q.port_b_pins & ~ddrb_q),
							acr_q, pb7_q);
					end
					via_pkg::RA_DDRA: rd_q <= ddra_q;
					via_pkg::RA_DDRB: rd_q <= ddrb_q;
					via_pkg::RA_T1LL: rd_q <= t1l_q[8:1];
					via_pkg::RA_T1LH: rd_q <= t1l_q[16:9];
					via_pkg::RA_T1CL: begin
						ifr_q[6] <= 1'b0;
						rd_q <= ($signed(t1c_q) < -19'sd1) ? 8'hFF : 8'((t1c_q + 19'd1) >> 1);
					end
					via_pkg::RA_T1CH:
						rd_q <= ($signed(t1c_q) < -19'sd1) ? 8'hFF : 8'((t1c_q + 19'd1) >> 9);
					via_pkg::RA_T2CL: begin
						ifr_q[5] <= 1'b0;
						rd_q <= 8'((t2c_q + 32'd1) >> 1);
					end
					via_pkg::RA_T2CH: rd_q <= 8'((t2c_q + 32'd1) >> 9);
					via_pkg::RA_SR:  rd_q <= sh_st.data;
					via_pkg::RA_ACR: rd_q <= acr_q;
					via_pkg::RA_PCR: rd_q <= pcr_q;
					via_pkg::RA_IER: rd_q <= {1'b1, ier_q};
					// IFR bit 7 reads as the summary left by the previous item
					default: rd_q <= ifr_n;
					endcase
				end
				via_pkg::OP_TICK: begin
					t1c_q <= t1_sub[18:0];
					if (t1_under) begin
						if (!t1d_q) begin
							ifr_q[6] <= 1'b1;
							t1x_q <= 1'b1;
							if (acr_q[7]) pb7_q <= ~pb7_q;
						end
						if (!acr_q[6]) t1d_q <= 1'b1;
					end
					if (!acr_q[5]) begin
						t2c_q <= t2_sub;
						if (t2_sub[31] && t2_sub < 32'hFFFFFFFD && !t2d_q) begin
							ifr_q[5] <= 1'b1;
							t2d_q <= 1'b1;
						end
					end
				end
				via_pkg::OP_CA1: begin
					if (item_q.line_level != lv_q[0]) begin
						if (pcr_q[0] == item_q.line_level) begin
							if (acr_q[0]) ila_q <= item_q.port_a_pins;
							ifr_q[1] <= 1'b1;
							if (pcr_q[3:2] == 2'b10) lv_q[1] <= 1'b1;
						end
						lv_q[0] <= item_q.line_level;
					end
				end
				via_pkg::OP_CA2: begin
					if (item_q.line_level != lv_q[1] && !pcr_q[3]) begin
						if (pcr_q[2] == item_q.line_level) ifr_q[0] <= 1'b1;
						lv_q[1] <= item_q.line_level;
					end
				end
				via_pkg::OP_CB1: begin
					if (item_q.line_level != lv_q[2]) begin
						if (pcr_q[4] == item_q.line_level) begin
							if (acr_q[1])
								ilb_q <= pb7m(item_q.port_b_pins & ~ddrb_q, acr_q, pb7_q);
							ifr_q[4] <= 1'b1;
							if (pcr_q[7:6] == 2'b10) lv_q[3] <= 1'b1;
						end
						lv_q[2] <= item_q.line_level;
					end
				end
				via_pkg::OP_CB2: begin
					if (item_q.line_level != lv_q[3] && !pcr_q[7]) begin
						if (pcr_q[6] == item_q.line_level) ifr_q[3] <= 1'b1;
						lv_q[3] <= item_q.line_level;
					end
				end
				default: ;
				endcase
			end
			ST_RELD: begin
				// one latch + 4 add per cycle until the count is at -3 or above
				t1c_q <= t1_rel[18:0];
				if (t1_rel >= -20'sd3) state_q <= shifting ? ST_SHFT : ST_DONE;
			end
			ST_SHFT: begin
				if (cyc_q == '0) state_q <= ST_DONE;
				else begin
					cyc_q <= cyc_q - CW'(1);
					if (sh_empty) ifr_q[2] <= 1'b1;
				end
			end
			ST_DONE: begin
				if (out_ready) state_q <= ST_IDLE;
			end
			default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_comb begin
		out_data.read_data      = rd_q;
		out_data.port_a_drive   = (ora_q & ddra_q) | ~ddra_q;
		out_data.port_b_drive   = pb7m((orb_q & ddrb_q) | ~ddrb_q, acr_q, pb7_q);
		out_data.ca2_drive      = pcr_q[3] & lv_q[1];
		out_data.ca2_pulse      = ca2p_q;
		out_data.cb1_drive      = shifting & sh_st.lines[0];
		out_data.cb2_drive      = shifting ? sh_st.lines[1] : (pcr_q[7] & lv_q[3]);
		out_data.cb2_pulse      = cb2p_q;
		out_data.irq_active     = ifr_n[7];
		out_data.force_irq      = force_q;
		out_data.timer1_expired = t1x_q;
	end

	// result only while done; never ready and valid together
	assert property (@(posedge clk) disable iff (!arst_n) !(in_ready && out_valid))
		else $error("in_ready and out_valid both high");
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == ST_EXEC))
		else $error("accepted item did not start");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EXEC) && (item_q.opcode != via_pkg::OP_TICK) |=> out_valid)
		else $error("single-step item did not finish");
endmodule

@@ dv/via_checker.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// via_checker: channel monitor and result predictor for the adapter
// Mirrors the adapter state, predicts one result per accepted item and
// compares each returned result field by field, in order.
// ---------------------------------------------------------------------------
module via_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_ready,
	input  via_pkg::in_item_t  in_data,
	input  logic               out_valid,
	input  logic               out_ready,
	input  via_pkg::out_item_t out_data,
	output int                 errors,
	output int                 pending
);

	localparam int TICK_CAP = 15;
	localparam int RELOAD_FLOOR = -3;

	logic [7:0]  ora, orb, ddra, ddrb, ila, ilb, sr_data, acr, pcr, ifr;
	logic [6:0]  ier;
	logic [4:0]  sr_cnt;
	logic [16:0] t1_lat, t2_lat;
	int          t1_cnt;
	logic [31:0] t2_cnt;
	logic        t1_done, t2_done, pb7;
	logic [3:0]  lines;   // CA1, CA2, CB1, CB2 levels
	logic [1:0]  sh_lines; // shift clock, shift data
	via_pkg::out_item_t results_due[$];
	int          err_count = 0;
	int          due_count = 0;

	assign errors  = err_count;
	assign pending = due_count;

	function automatic logic [7:0] pb7_merge(logic [7:0] v);
		if (acr[7])
			v[7] = pb7;
		return v;
	endfunction

	function automatic bit edge_hit(logic sel, logic lvl);
		return sel == lvl;
	endfunction

	task automatic clear_a_flags();
		ifr &= ~via_pkg::FL_CA1;
		if ((pcr & 8'h0A) != 8'h02)
			ifr &= ~via_pkg::FL_CA2;
	endtask

	task automatic clear_b_flags();
		ifr &= ~via_pkg::FL_CB1;
		if ((pcr & 8'hA0) != 8'h20)
			ifr &= ~via_pkg::FL_CB2;
	endtask

	task automatic predict_item(input via_pkg::in_item_t it, output via_pkg::out_item_t r);
		logic [7:0] rd;
		logic [7:0] v;
		logic [7:0] pa;
		logic [7:0] pb;
		logic       lvl;
		logic       sclk;
		logic       shifting;
		int         cyc;
		bit         ca2p, cb2p, frc, t1x;
		rd = 8'h00;
		v = it.write_data;
		pa = it.port_a_pins;
		pb = it.port_b_pins;
		lvl = it.line_level;
		cyc = (it.tick_cycles > TICK_CAP) ? TICK_CAP : it.tick_cycles;
		{ca2p, cb2p, frc, t1x} = 4'b0;
		case (via_pkg::opcode_t'(it.opcode))
			via_pkg::OP_WRITE: begin
				case (it.reg_addr)
					via_pkg::RA_ORA: begin
						clear_a_flags();
						if ((pcr & 8'h0E) == 8'h08) lines[1] = 1'b0;
						if ((pcr & 8'h0E) == 8'h0A) begin
							ca2p = 1'b1;
							lines[1] = 1'b1;
						end
						ora = v;
					end
					via_pkg::RA_ORAN: ora = v;
					via_pkg::RA_ORB: begin
						clear_b_flags();
						orb = v;
						if ((pcr & 8'hE0) == 8'h80) lines[3] = 1'b0;
						if ((pcr & 8'hE0) == 8'hA0) begin
							cb2p = 1'b1;
							lines[3] = 1'b1;
						end
					end
					via_pkg::RA_DDRA: ddra = v;
					via_pkg::RA_DDRB: ddrb = v;
					via_pkg::RA_ACR: begin
						acr = v;
						if (!v[7]) pb7 = 1'b1;
					end
					via_pkg::RA_PCR: begin
						pcr = v;
						if ((v & 8'h0E) == 8'h0C) lines[1] = 1'b0;
						else if (v[3]) lines[1] = 1'b1;
						if ((v & 8'hE0) == 8'hC0) lines[3] = 1'b0;
						else if (v[7]) lines[3] = 1'b1;
					end
					via_pkg::RA_SR: begin
						sr_data = v;
						sr_cnt = 5'd16;
						ifr &= ~via_pkg::FL_SR;
					end
					via_pkg::RA_T1CL, via_pkg::RA_T1LL: t1_lat = {t1_lat[16:9], v, 1'b0};
					via_pkg::RA_T1LH: begin
						t1_lat = {v, t1_lat[8:0]};
						ifr &= ~via_pkg::FL_T1;
					end
					via_pkg::RA_T1CH: begin
						if ((acr & 8'hC0) == 8'h80) pb7 = 1'b0;
						t1_lat = {v, t1_lat[8:0]};
						t1_cnt = int'(t1_lat) + 1;
						t1_done = 1'b0;
						ifr &= ~via_pkg::FL_T1;
					end
					via_pkg::RA_T2CL: t2_lat = {t2_lat[16:9], v, 1'b0};
					via_pkg::RA_T2CH: begin
						if ((t2_cnt == 32'hFFFF_FFFD && (ier & via_pkg::FL_T2[6:0]) != 0) ||
								(ifr & {1'b0, ier} & via_pkg::FL_T2) != 0)
							frc = 1'b1;
						t2_lat = {v, t2_lat[8:0]};
						t2_cnt = acr[5] ? {15'd0, t2_lat} : {15'd0, t2_lat} + 32'd1;
						ifr &= ~via_pkg::FL_T2;
						t2_done = 1'b0;
					end
					via_pkg::RA_IER: begin
						if (v[7]) ier |= v[6:0];
						else ier &= ~v[6:0];
					end
					default: ifr &= ~{1'b0, v[6:0]};
				endcase
			end
			via_pkg::OP_READ: begin
				case (it.reg_addr)
					via_pkg::RA_ORA, via_pkg::RA_ORAN: begin
						if (it.reg_addr == via_pkg::RA_ORA) clear_a_flags();
						rd = (ora & ddra) | ((acr[0] ? ila : pa) & ~ddra);
					end
					via_pkg::RA_ORB: begin
						clear_b_flags();
						rd = orb & ddrb;
						if (acr[1]) rd |= ilb & ~ddrb;
						else rd = pb7_merge(rd | (pb & ~ddrb));
					end
					via_pkg::RA_DDRA: rd = ddra;
					via_pkg::RA_DDRB: rd = ddrb;
					via_pkg::RA_T1LL: rd = t1_lat[8:1];
					via_pkg::RA_T1LH: rd = t1_lat[16:9];
					via_pkg::RA_T1CL: begin
						ifr &= ~via_pkg::FL_T1;
						rd = (t1_cnt < -1) ? 8'hFF : 8'((t1_cnt + 1) >> 1);
					end
					via_pkg::RA_T1CH: rd = (t1_cnt < -1) ? 8'hFF : 8'((t1_cnt + 1) >> 9);
					via_pkg::RA_T2CL: begin
						ifr &= ~via_pkg::FL_T2;
						rd = 8'((t2_cnt + 32'd1) >> 1);
					end
					via_pkg::RA_T2CH: rd = 8'((t2_cnt + 32'd1) >> 9);
					via_pkg::RA_SR: rd = sr_data;
					via_pkg::RA_ACR: rd = acr;
					via_pkg::RA_PCR: rd = pcr;
					via_pkg::RA_IER: rd = {1'b1, ier};
					default: rd = ifr;
				endcase
			end
			via_pkg::OP_TICK: begin
				t1_cnt -= cyc;
				if (t1_cnt < RELOAD_FLOOR) begin
					while (t1_cnt < RELOAD_FLOOR)
						t1_cnt += int'(t1_lat) + 4;
					if (!t1_done) begin
						ifr |= via_pkg::FL_T1;
						t1x = 1'b1;
						if (acr[7]) pb7 = ~pb7;
					end
					if (!acr[6]) t1_done = 1'b1;
				end
				if (!acr[5]) begin
					t2_cnt -= 32'(cyc);
					// wrapped below the floor: one-shot interrupt
					if (t2_cnt >= 32'h8000_0000 && t2_cnt < 32'hFFFF_FFFD && !t2_done) begin
						ifr |= via_pkg::FL_T2;
						t2_done = 1'b1;
					end
				end
				if ((acr & 8'h1C) == 8'h18) begin
					for (int i = 0; i < cyc; i++) begin
						if (sr_cnt > 0) begin
							sclk = ~sr_cnt[0];
							sr_cnt--;
							if (sclk) begin
								sh_lines[1] = sr_data[7];
								sr_data = sr_data << 1;
							end
							sh_lines[0] = sclk;
						end
						if (sr_cnt == 0) ifr |= via_pkg::FL_SR;
					end
				end
			end
			via_pkg::OP_CA1: begin
				if (lvl != lines[0]) begin
					if (edge_hit(pcr[0], lvl)) begin
						if (acr[0]) ila = pa;
						ifr |= via_pkg::FL_CA1;
						if ((pcr & 8'h0C) == 8'h08) lines[1] = 1'b1;
					end
					lines[0] = lvl;
				end
			end
			via_pkg::OP_CA2: begin
				if (lvl != lines[1] && !pcr[3]) begin
					if (edge_hit(pcr[2], lvl)) ifr |= via_pkg::FL_CA2;
					lines[1] = lvl;
				end
			end
			via_pkg::OP_CB1: begin
				if (lvl != lines[2]) begin
					if (edge_hit(pcr[4], lvl)) begin
						if (acr[1]) ilb = pb7_merge(pb & ~ddrb);
						ifr |= via_pkg::FL_CB1;
						if ((pcr & 8'hC0) == 8'h80) lines[3] = 1'b1;
					end
					lines[2] = lvl;
				end
			end
			via_pkg::OP_CB2: begin
				if (lvl != lines[3] && !pcr[7]) begin
					if (edge_hit(pcr[6], lvl)) ifr |= via_pkg::FL_CB2;
					lines[3] = lvl;
				end
			end
			default: ;
		endcase
		ifr[7] = (ifr[6:0] & ier) != 0;
		shifting = (acr & 8'h1C) == 8'h18;
		r.read_data = rd;
		r.port_a_drive = (ora & ddra) | ~ddra;
		r.port_b_drive = pb7_merge((orb & ddrb) | ~ddrb);
		r.ca2_drive = pcr[3] ? lines[1] : 1'b0;
		r.ca2_pulse = ca2p;
		r.cb1_drive = shifting ? sh_lines[0] : 1'b0;
		r.cb2_drive = shifting ? sh_lines[1] : (pcr[7] ? lines[3] : 1'b0);
		r.cb2_pulse = cb2p;
		r.irq_active = ifr[7];
		r.force_irq = frc;
		r.timer1_expired = t1x;
	endtask

	function automatic int field_bad(string name, int want, int got);
		if (want != got) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			return 1;
		end
		return 0;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		via_pkg::out_item_t want;
		int bad;
		if (!arst_n) begin
			{ora, orb, ddra, ddrb, ila, ilb, sr_data, acr, pcr, ifr} = '0;
			ier = '0;
			sr_cnt = '0;
			t1_lat = via_pkg::TIMER_RESET;
			t2_lat = via_pkg::TIMER_RESET;
			t1_cnt = int'(via_pkg::TIMER_RESET);
			t2_cnt = {15'd0, via_pkg::TIMER_RESET};
			{t1_done, t2_done, pb7} = 3'b111;
			lines = '0;
			sh_lines = '0;
		end else begin
			if (in_valid && in_ready) begin
				predict_item(in_data, want);
				results_due.push_back(want);
			end
			if (out_valid && out_ready) begin
				if (results_due.size() == 0) begin
					$error("result returned with no item outstanding");
					err_count++;
				end else begin
					want = results_due.pop_front();
					bad = 0;
					bad += field_bad("read_data", want.read_data, out_data.read_data);
					bad += field_bad("port_a_drive", want.port_a_drive, out_data.port_a_drive);
					bad += field_bad("port_b_drive", want.port_b_drive, out_data.port_b_drive);
					bad += field_bad("ca2_drive", want.ca2_drive, out_data.ca2_drive);
					bad += field_bad("ca2_pulse", want.ca2_pulse, out_data.ca2_pulse);
					bad += field_bad("cb1_drive", want.cb1_drive, out_data.cb1_drive);
					bad += field_bad("cb2_drive", want.cb2_drive, out_data.cb2_drive);
					bad += field_bad("cb2_pulse", want.cb2_pulse, out_data.cb2_pulse);
					bad += field_bad("irq_active", want.irq_active, out_data.irq_active);
					bad += field_bad("force_irq", want.force_irq, out_data.force_irq);
					bad += field_bad("timer1_expired", want.timer1_expired,
						out_data.timer1_expired);
					err_count += bad;
				end
			end
		end
		due_count = results_due.size();
	end

endmodule

@@ dv/versatile_interface_adapter_tb.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// versatile_interface_adapter_tb: top-level testbench
// Drives a directed opening sequence and then randomized register, timer,
// shift and control-line traffic with bursty input and a stalling output;
// via_checker predicts and compares every result.
// ---------------------------------------------------------------------------
module versatile_interface_adapter_tb;

	localparam int RANDOM_ITEMS = 1350;
	localparam int IDLE_LIMIT = 4000; // cycles with no handshake at all
	localparam int DRAIN_CYCLES = 40; // exceeds the worst-case item latency

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	via_pkg::in_item_t  in_data;
	logic               out_valid;
	logic               out_ready = 1'b0;
	via_pkg::out_item_t out_data;
	int                 errors;
	int                 pending;
	int                 idle_cycles = 0;
	int                 burst_left;

	versatile_interface_adapter uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	via_checker u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.errors(errors),
		.pending(pending)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	// Receiver: stall probability is redrawn periodically; some windows never stall.
	int stall_pct = 0;
	int rx_cycle = 0;
	always @(posedge clk) begin
		if (rx_cycle % 64 == 0) begin
			case ($urandom_range(0, 3))
				0: stall_pct <= 0;
				1: stall_pct <= 20;
				2: stall_pct <= 50;
				default: stall_pct <= 80;
			endcase
		end
		rx_cycle <= rx_cycle + 1;
		out_ready <= ($urandom_range(0, 99) >= stall_pct);
	end

	// Watchdog: any handshake resets the count.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	function automatic via_pkg::in_item_t make_item(via_pkg::opcode_t op, logic [3:0] ra,
			logic [7:0] wd, logic lvl, logic [3:0] cyc);
		via_pkg::in_item_t it;
		it.opcode = op;
		it.reg_addr = ra;
		it.write_data = wd;
		it.line_level = lvl;
		it.tick_cycles = cyc;
		it.port_a_pins = 8'($urandom);
		it.port_b_pins = 8'($urandom);
		return it;
	endfunction

	// Random traffic weighted toward short timers so expiries and reloads happen often.
	function automatic via_pkg::in_item_t random_item();
		via_pkg::in_item_t it;
		int pick;
		it = 36'({$urandom, $urandom});
		it.port_a_pins = 8'($urandom);
		it.port_b_pins = 8'($urandom);
		pick = $urandom_range(0, 99);
		if (pick < 35) begin
			it.opcode = via_pkg::OP_WRITE;
			if ((it.reg_addr == via_pkg::RA_T1CH || it.reg_addr == via_pkg::RA_T1LH
					|| it.reg_addr == via_pkg::RA_T2CH) && $urandom_range(0, 3) != 0)
				it.write_data = 8'($urandom_range(0, 2));
		end else if (pick < 60) begin
			it.opcode = via_pkg::OP_READ;
		end else if (pick < 85) begin
			it.opcode = via_pkg::OP_TICK;
			if ($urandom_range(0, 40) == 0) it.tick_cycles = 4'd0;
		end else if (pick < 99) begin
			it.opcode = via_pkg::opcode_t'($urandom_range(via_pkg::OP_CA1, via_pkg::OP_CB2));
		end else begin
			it.opcode = via_pkg::OP_NONE;
		end
		return it;
	endfunction

	// Holds valid across back-to-back items inside a burst; drops it only for a gap.
	task automatic send_item(input via_pkg::in_item_t it);
		int gap;
		in_valid <= 1'b1;
		in_data <= it;
		do @(posedge clk); while (!in_ready);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 12);
			gap = $urandom_range(1, 6);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	initial begin
		via_pkg::in_item_t opening[$];
		in_valid = 1'b0;
		in_data = '0;
		burst_left = 0;
		arst_n = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed opening: port extremes, timers, shift out, every control line.
		opening.push_back(make_item(via_pkg::OP_READ, via_pkg::RA_T1CH, 8'h00, 1'b0, 4'd1));
		opening.push_back(make_item(via_pkg::OP_WRITE, via_pkg::RA_DDRA, 8'hFF, 1'b0, 4'd1));
		opening.push_back(make_item(via_pkg::OP_WRITE, via_pkg::RA_ORA, 8'hA5, 1'b0, 4'd1));
		opening.push_back(make_item(via_pkg::OP_WRITE, via_pkg::RA_DDRB, 8'h0F, 1'b0, 4'd1));
		opening.push_back(make_item(via_pkg::OP_WRITE, via_pkg::RA_IER, 8'hFF, 1'b0, 4'd1));
		opening.push_back(make_item(via_pkg::OP_WRITE, via_pkg::RA_ACR, 8'hD8, 1'b0, 4'd1));
		opening.push_back(make_item(via_pkg::OP_WRITE, via_pkg::RA_PCR, 8'hAA, 1'b0, 4'd1));
		opening.push_back(make_item(via_pkg::OP_WRITE, via_pkg::RA_T1CL, 8'h03, 1'b0, 4'd1));
		opening.push_back(make_item(via_pkg::OP_WRITE, via_pkg::RA_T1CH, 8'h00, 1'b0, 4'd1));
		opening.push_back(make_item(via_pkg::OP_WRITE, via_pkg::RA_SR, 8'hC3, 1'b0, 4'd1));
		opening.push_back(make_item(via_pkg::OP_TICK, via_pkg::RA_ORB, 8'h00, 1'b0, 4'd0));
		opening.push_back(make_item(via_pkg::OP_TICK, via_pkg::RA_ORB, 8'h00, 1'b0, 4'd15));
		opening.push_back(make_item(via_pkg::OP_TICK, via_pkg::RA_ORB, 8'h00, 1'b0, 4'd15));
		opening.push_back(make_item(via_pkg::OP_READ, via_pkg::RA_T1CL, 8'h00, 1'b0, 4'd1));
		opening.push_back(make_item(via_pkg::OP_WRITE, via_pkg::RA_ORA, 8'h5A, 1'b0, 4'd1));
		opening.push_back(make_item(via_pkg::OP_WRITE, via_pkg::RA_ORB, 8'hFF, 1'b0, 4'd1));
		opening.push_back(make_item(via_pkg::OP_WRITE, via_pkg::RA_T2CL, 8'h02, 1'b0, 4'd1));
		opening.push_back(make_item(via_pkg::OP_WRITE, via_pkg::RA_T2CH, 8'h00, 1'b0, 4'd1));
		opening.push_back(make_item(via_pkg::OP_TICK, via_pkg::RA_ORB, 8'h00, 1'b0, 4'd9));
		opening.push_back(make_item(via_pkg::OP_WRITE, via_pkg::RA_T2CH, 8'hFF, 1'b0, 4'd1));
		opening.push_back(make_item(via_pkg::OP_CA1, via_pkg::RA_ORB, 8'h00, 1'b1, 4'd1));
		opening.push_back(make_item(via_pkg::OP_CA2, via_pkg::RA_ORB, 8'h00, 1'b1, 4'd1));
		opening.push_back(make_item(via_pkg::OP_CB1, via_pkg::RA_ORB, 8'h00, 1'b1, 4'd1));
		opening.push_back(make_item(via_pkg::OP_CB2, via_pkg::RA_ORB, 8'h00, 1'b1, 4'd1));
		opening.push_back(make_item(via_pkg::OP_NONE, via_pkg::RA_IFR, 8'h00, 1'b0, 4'd1));
		opening.push_back(make_item(via_pkg::OP_READ, via_pkg::RA_IFR, 8'h00, 1'b0, 4'd1));
		foreach (opening[i])
			send_item(opening[i]);

		for (int n = 0; n < RANDOM_ITEMS; n++)
			send_item(random_item());
		in_valid <= 1'b0;

		// one edge so the last accepted item is counted as outstanding
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
